### rtl/rgbenc_pkg.sv
`timescale 1ns / 1ps

package rgbenc_pkg;

  typedef enum logic [1:0] {
    OP_SET_ONE = 2'd0,
    OP_SET_ALL = 2'd1,
    OP_REFRESH = 2'd2,
    OP_TICK    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_LED_COUNT   = 2'd0,
    CFG_RESET_BYTES = 2'd1,
    CFG_ZERO_PAT    = 2'd2,
    CFG_ONE_PAT     = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_SWEEP
  } state_e;

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_DATA,
    PH_TRAIL
  } phase_e;

  localparam logic [7:0] LED_COUNT_RST   = 8'd83;
  localparam logic [7:0] RESET_BYTES_RST = 8'd60;
  localparam logic [7:0] ZERO_PAT_RST    = 8'hE0;
  localparam logic [7:0] ONE_PAT_RST     = 8'hFC;

  // Colour word bit index of the first bit sent (green MSB).
  localparam logic [4:0] TOP_BIT = 5'd23;

  // Wide enough to compare the 8-bit LED count with any supported store depth.
  localparam int unsigned CMP_W = 11;

endpackage

### rtl/rgb_led_chain_frame_encoder.sv
`timescale 1ns / 1ps

// Set one, refresh and idle tick give their result in the output register in the cycle after the transaction;
// a tick during a frame reads the colour store into rdata_q, passes through ST_EMIT, then registers its byte.
// Items are taken one at a time; a tick in a frame passes through ST_EMIT, and set all
// is followed by a sweep of the whole store through the single colour store write port.
// Reset: rst_ni clears control state, then the store is cleared in a sweep of all MAX_LEDS entries
// during which no input is taken; configuration writes are always taken.
module rgb_led_chain_frame_encoder #(
  parameter int unsigned MAX_LEDS = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input items.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // led_index[6:0], red[14:7], green[22:15], blue[30:23]
  input  logic [1:0]  s_axis_tuser,  // operation[1:0]
  // Results.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // accepted[0], line_byte[8:1], byte_valid[9], busy_res[10]
  output logic        m_axis_tlast,  // frame_last
  // Configuration writes.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import rgbenc_pkg::*;

  localparam int unsigned AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

  // Configuration registers.
  logic [7:0] led_count_q, reset_bytes_q, zero_pat_q, one_pat_q;

  // Sequencer state.
  state_e        state_q, state_d;
  phase_e        phase_q, phase_d;
  logic          sending_q, sending_d;
  logic [7:0]    run_q, run_d;
  logic [7:0]    led_q, led_d;
  logic [4:0]    bit_q, bit_d;
  logic [7:0]    frame_leds_q, frame_leds_d;
  logic [7:0]    frame_reset_q, frame_reset_d;
  logic [AW-1:0] sweep_q, sweep_d;
  logic [23:0]   fill_q, fill_d;

  // Output register.
  logic        out_valid_q, out_valid_d;
  logic [10:0] out_data_q, out_data_d;
  logic        out_last_q, out_last_d;

  // Colour store.
  logic [23:0]   mem [MAX_LEDS];
  logic [23:0]   rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [23:0]   mem_wdata;
  logic [AW-1:0] rd_addr;

  // Decoded input fields.
  op_e        in_op;
  logic [6:0] in_idx;
  logic [7:0] in_red, in_green, in_blue;
  logic [23:0] in_colour;
  logic        in_fire;

  logic [7:0]       eff_leds;
  logic [CMP_W-1:0] lc_ext;
  logic [AW+7:0]    idx_ext, led_ext;

  // Shared increment and compare unit of the frame sequencer.
  logic [7:0] inc_src, inc_lim;
  logic [8:0] inc_sum;
  logic       inc_hit;

  logic [7:0] data_byte;

  assign in_op     = op_e'(s_axis_tuser);
  assign in_idx    = s_axis_tdata[6:0];
  assign in_red    = s_axis_tdata[14:7];
  assign in_green  = s_axis_tdata[22:15];
  assign in_blue   = s_axis_tdata[30:23];
  assign in_colour = {in_green, in_red, in_blue};

  assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign lc_ext   = CMP_W'(led_count_q);
  assign eff_leds = (lc_ext > CMP_W'(MAX_LEDS)) ? 8'(MAX_LEDS) : led_count_q;

  assign idx_ext = {{(AW + 1){1'b0}}, in_idx};
  assign led_ext = {{AW{1'b0}}, led_q};
  assign rd_addr = led_ext[AW-1:0];

  assign inc_src = (phase_q == PH_DATA) ? led_q : run_q;
  assign inc_lim = (phase_q == PH_DATA) ? frame_leds_q : frame_reset_q;
  assign inc_sum = {1'b0, inc_src} + 9'd1;
  assign inc_hit = (inc_sum[7:0] == inc_lim);

  assign data_byte = rdata_q[bit_q] ? one_pat_q : zero_pat_q;

  always_comb begin
    state_d       = state_q;
    phase_d       = phase_q;
    sending_d     = sending_q;
    run_d         = run_q;
    led_d         = led_q;
    bit_d         = bit_q;
    frame_leds_d  = frame_leds_q;
    frame_reset_d = frame_reset_q;
    sweep_d       = sweep_q;
    fill_d        = fill_q;
    out_valid_d   = out_valid_q && !m_axis_tready;
    out_data_d    = out_data_q;
    out_last_d    = out_last_q;
    mem_we        = 1'b0;
    mem_waddr     = sweep_q;
    mem_wdata     = fill_q;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          out_valid_d = 1'b1;
          out_last_d  = 1'b0;
          out_data_d  = {sending_q, 1'b0, 8'h00, 1'b0};
          case (in_op)
            OP_SET_ONE: begin
              if (8'(in_idx) < eff_leds) begin
                mem_we     = 1'b1;
                mem_waddr  = idx_ext[AW-1:0];
                mem_wdata  = in_colour;
                out_data_d = {sending_q, 1'b0, 8'h00, 1'b1};
              end
            end
            OP_SET_ALL: begin
              fill_d     = in_colour;
              sweep_d    = '0;
              state_d    = ST_SWEEP;
              out_data_d = {sending_q, 1'b0, 8'h00, 1'b1};
            end
            OP_REFRESH: begin
              if (!sending_q) begin
                sending_d     = 1'b1;
                phase_d       = PH_LEAD;
                run_d         = '0;
                frame_leds_d  = eff_leds;
                frame_reset_d = (reset_bytes_q == 8'd0) ? 8'd1 : reset_bytes_q;
                out_data_d    = {1'b1, 1'b0, 8'h00, 1'b1};
              end
            end
            OP_TICK: begin
              // A tick in a frame goes through ST_EMIT while the colour word is read.
              if (sending_q) begin
                out_valid_d = 1'b0;
                state_d     = ST_EMIT;
              end
            end
            default: ;
          endcase
        end
      end

      ST_EMIT: begin
        state_d     = ST_IDLE;
        out_valid_d = 1'b1;
        out_last_d  = 1'b0;
        case (phase_q)
          PH_LEAD: begin
            out_data_d = {1'b1, 1'b1, 8'h00, 1'b1};
            if (inc_hit) begin
              run_d = '0;
              if (frame_leds_q == 8'd0) begin
                phase_d = PH_TRAIL;
              end else begin
                phase_d = PH_DATA;
                led_d   = '0;
                bit_d   = TOP_BIT;
              end
            end else begin
              run_d = inc_sum[7:0];
            end
          end
          PH_DATA: begin
            out_data_d = {1'b1, 1'b1, data_byte, 1'b1};
            if (bit_q == 5'd0) begin
              bit_d = TOP_BIT;
              led_d = inc_sum[7:0];
              if (inc_hit) begin
                phase_d = PH_TRAIL;
                run_d   = '0;
              end
            end else begin
              bit_d = bit_q - 5'd1;
            end
          end
          default: begin
            if (inc_hit) begin
              out_data_d = {1'b0, 1'b1, 8'h00, 1'b1};
              out_last_d = 1'b1;
              sending_d  = 1'b0;
              phase_d    = PH_LEAD;
              run_d      = '0;
            end else begin
              out_data_d = {1'b1, 1'b1, 8'h00, 1'b1};
              run_d      = inc_sum[7:0];
            end
          end
        endcase
      end

      ST_SWEEP: begin
        mem_we  = 1'b1;
        sweep_d = sweep_q + AW'(1);
        if (sweep_q == AW'(MAX_LEDS - 1)) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_SWEEP;
      phase_q       <= PH_LEAD;
      sending_q     <= 1'b0;
      run_q         <= '0;
      led_q         <= '0;
      bit_q         <= TOP_BIT;
      frame_leds_q  <= '0;
      frame_reset_q <= 8'd1;
      sweep_q       <= '0;
      fill_q        <= '0;
      out_valid_q   <= 1'b0;
      out_last_q    <= 1'b0;
    end else begin
      state_q       <= state_d;
      phase_q       <= phase_d;
      sending_q     <= sending_d;
      run_q         <= run_d;
      led_q         <= led_d;
      bit_q         <= bit_d;
      frame_leds_q  <= frame_leds_d;
      frame_reset_q <= frame_reset_d;
      sweep_q       <= sweep_d;
      fill_q        <= fill_d;
      out_valid_q   <= out_valid_d;
      out_last_q    <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_count_q   <= LED_COUNT_RST;
      reset_bytes_q <= RESET_BYTES_RST;
      zero_pat_q    <= ZERO_PAT_RST;
      one_pat_q     <= ONE_PAT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_LED_COUNT:   led_count_q   <= cfg_data_i;
        CFG_RESET_BYTES: reset_bytes_q <= cfg_data_i;
        CFG_ZERO_PAT:    zero_pat_q    <= cfg_data_i;
        CFG_ONE_PAT:     one_pat_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // The word of the LED being sent is read at the tick transaction itself.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[rd_addr];
  end

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_data_q};
  assign m_axis_tlast  = out_last_q;

  // The byte of a frame tick is only computed once the output register is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> !out_valid_q)
    else $error("output register occupied while a frame byte is being produced");

  // The final byte of a frame leaves the encoder idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> (!sending_q && !out_data_q[10]))
    else $error("frame end flagged while still sending");

  // Between frames the sequencer rests at the start of the leading reset run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sending_q |-> (phase_q == PH_LEAD && run_q == 8'd0))
    else $error("frame sequencer not rewound while idle");

  // A frame tick is only taken on while a frame is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> $past(sending_q))
    else $error("frame byte produced without an active frame");

endmodule
